// File: sv/assert_macros.svh
// Assertion macros for the survivor block; empty when synthesizing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define JS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("josephus_survivor: assertion failed");
`define JS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("josephus_survivor: assertion failed");
`else
`define JS_ASSERT(lbl, prop)
`define JS_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// File: sv/jos_pkg.sv
// Shared widths for the Josephus survivor block.
`default_nettype none
package jos_pkg;
  localparam int unsigned CNT_W  = 11;
  localparam int unsigned STEP_W = 16;
endpackage
`default_nettype wire

// File: sv/josephus_survivor.sv
// Josephus survivor: iterative r = (r + step) mod i with a bit-serial remainder unit.
//
//   channel | direction | signals
//   in      | request   | in_valid_i, in_ready_o, people_count_i, step_size_i
//   out     | result    | out_valid_o, out_ready_i, survivor_o, bad_query_o
//
// Each recurrence step is an add state (S_ADD) and a restoring remainder loop (S_DIV)
// over the SUM_W bits of the sum, one bit a cycle; SUM_W is 17 at default widths.
// Rejected requests and a count of one go straight from idle to S_FIN.
// Reset clears the sequencer and the output valid; no clearing pass.
// in_ready_o is high only while the sequencer is idle; a finished result waits
// in the output register while a new request is already being worked on.
`default_nettype none
`include "assert_macros.svh"
module josephus_survivor #(
  parameter int MAX_COUNT = 1024,
  parameter int STEP_BITS = 16
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       in_valid_i,
  output logic                      in_ready_o,
  input  wire  [jos_pkg::CNT_W-1:0]  people_count_i,
  input  wire  [jos_pkg::STEP_W-1:0] step_size_i,
  output logic                      out_valid_o,
  input  wire                       out_ready_i,
  output logic [jos_pkg::CNT_W-1:0]  survivor_o,
  output logic                      bad_query_o
);
  import jos_pkg::*;

  // effective step width after masking
  localparam int SB    = (STEP_BITS < STEP_W) ? STEP_BITS : STEP_W;
  localparam int SUM_W = ((SB > CNT_W) ? SB : CNT_W) + 1;
  localparam int BW    = $clog2(SUM_W);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ADD  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] i_q, i_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic [SB-1:0]    step_q, step_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [BW-1:0]    bit_q, bit_d;
  logic             bad_q, bad_d;
  logic             out_valid_q, out_valid_d;
  logic [CNT_W-1:0] surv_q, surv_d;
  logic             badq_q, badq_d;

  logic [SB-1:0]    step_in;
  logic             in_bad;
  logic [CNT_W:0]   shifted;
  logic [CNT_W:0]   div_diff;
  logic             fits;
  logic [CNT_W-1:0] rem_next;
  logic             accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign step_in    = step_size_i[SB-1:0];
  assign in_bad     = (people_count_i == '0) || (step_in == '0) ||
                      (32'(people_count_i) > 32'(MAX_COUNT));

  // restoring-division step used by the S_DIV state
  assign shifted  = {rem_q, sum_q[SUM_W-1]};
  assign div_diff = shifted - {1'b0, i_q};
  assign fits     = (shifted >= {1'b0, i_q});
  assign rem_next = fits ? div_diff[CNT_W-1:0] : shifted[CNT_W-1:0];

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    i_d         = i_q;
    rem_d       = rem_q;
    step_d      = step_q;
    sum_d       = sum_q;
    bit_d       = bit_q;
    bad_d       = bad_q;
    surv_d      = surv_q;
    badq_d      = badq_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cnt_d  = people_count_i;
          step_d = step_in;
          bad_d  = in_bad;
          rem_d  = '0;
          i_d    = CNT_W'(2);
          if (in_bad || (people_count_i == CNT_W'(1))) begin
            state_d = S_FIN;
          end else begin
            state_d = S_ADD;
          end
        end
      end
      S_ADD: begin
        sum_d   = SUM_W'(rem_q) + SUM_W'(step_q);
        rem_d   = '0;
        bit_d   = BW'(SUM_W - 1);
        state_d = S_DIV;
      end
      S_DIV: begin
        rem_d = rem_next;
        sum_d = sum_q << 1;
        bit_d = bit_q - BW'(1);
        if (bit_q == '0) begin
          if (i_q == cnt_q) begin
            state_d = S_FIN;
          end else begin
            i_d     = i_q + CNT_W'(1);
            state_d = S_ADD;
          end
        end
      end
      S_FIN: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          surv_d      = bad_q ? '0 : (rem_q + CNT_W'(1));
          badq_d      = bad_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    i_q    <= i_d;
    rem_q  <= rem_d;
    step_q <= step_d;
    sum_q  <= sum_d;
    bit_q  <= bit_d;
    bad_q  <= bad_d;
    surv_q <= surv_d;
    badq_q <= badq_d;
  end

  assign out_valid_o = out_valid_q;
  assign survivor_o  = surv_q;
  assign bad_query_o = badq_q;

  `JS_ASSERT(a_rem_below_mod, (state_q == S_DIV) |-> (rem_q < i_q))
  `JS_ASSERT(a_bad_zero, (out_valid_o && bad_query_o) |-> (survivor_o == '0))
  `JS_ASSERT(a_good_nonzero, (out_valid_o && !bad_query_o) |-> (survivor_o != '0))
  `JS_ASSERT(a_busy_after_accept, (in_valid_i && in_ready_o) |=> !in_ready_o)
  `JS_ASSERT_ALWAYS(a_reset_quiet, $rose(rst_ni) |-> !out_valid_o)

endmodule
`default_nettype wire
